@@ rtl/core/ric_pkg.sv @@
package ric_pkg;
   localparam logic [2:0] ST_HIT         = 3'd0;
   localparam logic [2:0] ST_LOAD_FREE   = 3'd1;
   localparam logic [2:0] ST_REPLACE     = 3'd2;
   localparam logic [2:0] ST_FULL        = 3'd3;
   localparam logic [2:0] ST_RELEASED    = 3'd4;
   localparam logic [2:0] ST_RELEASED_WB = 3'd5;
   localparam logic [2:0] ST_IGNORED     = 3'd6;

   localparam logic OP_GET     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam int ENTRY_W = 66;

   // inodes per disk block; a power of two so block and slot come from a shift and a mask
   localparam int INODES_PER_BLOCK = 8;

   typedef struct packed {
      logic        cached;
      logic [7:0]  device;
      logic [31:0] inode;
      logic [7:0]  share;
      logic [15:0] uses;
      logic        dirty;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  device;
      logic [31:0] inode_number;
      logic [5:0]  entry_index;
      logic        dirty_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_out;
      logic        load_request;
      logic        writeback_request;
      logic [31:0] disk_block;
      logic [2:0]  block_offset;
      logic [7:0]  device_out;
   } rsp_type;
endpackage

@@ rtl/core/ric_req_if.sv @@
interface ric_req_if;
   import ric_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ric_rsp_if.sv @@
interface ric_rsp_if;
   import ric_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/refcounted_inode_cache.sv @@
// order: a release reads its entry, then updates it and shows the result; a get first sweeps
// all entries, then re-reads the target entry, then updates it and shows the result
// throughput: one word at a time; next word accepted the cycle after the result is taken
// reset: synchronous active high; after reset a clearing pass writes every entry free
// before the first word is accepted; csr writes are taken throughout
module refcounted_inode_cache #(
   parameter int ENTRIES          = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   ric_req_if.sink              req,
   ric_rsp_if.source            rsp
);
   import ric_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int SH = $clog2(INODES_PER_BLOCK);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [31:0] base_ff;
   req_type     cmd_ff, cmd_in;
   logic [AW:0] addr_ff, addr_in;       // issue address, one wider to hold ENTRIES
   logic        rvalid_ff, rvalid_in;   // read data returning this cycle
   logic [AW-1:0] raddr_ff, raddr_in;   // address of returning data
   logic        hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic        free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic        vic_ff, vic_in;
   logic [AW-1:0] vic_idx_ff, vic_idx_in;
   logic [15:0] vic_use_ff, vic_use_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_raw;

   ric_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   assign req.ready  = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid  = out_valid_ff;
   assign rsp.data   = out_ff;

   logic        rel_ok;
   logic [7:0]  share_dec;
   logic        bad_idx;

   always_comb begin
      share_dec = rd_data.share - 8'd1;
      bad_idx   = ({26'd0, cmd_ff.entry_index} >= 32'(ENTRIES));
      rel_ok    = !bad_idx && rd_data.cached && (rd_data.share != 8'd0);
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      rvalid_in = 1'b0;
      raddr_in  = raddr_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff;
      free_in = free_ff; free_idx_in = free_idx_ff;
      vic_in = vic_ff; vic_idx_in = vic_idx_ff; vic_use_in = vic_use_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      wr_en   = 1'b0;
      wr_addr = addr_ff[AW-1:0];
      wr_data = '0;
      rd_addr = addr_ff[AW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == (AW+1)'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               hit_in = 1'b0; free_in = 1'b0; vic_in = 1'b0;
               addr_in = '0;
               if (req.data.op == OP_GET) begin
                  state_in = S_SCAN;
               end else begin
                  addr_in  = {1'b0, AW'(req.data.entry_index)};
                  state_in = S_READ;
               end
            end
         end
         S_SCAN: begin
            if (addr_ff < (AW+1)'(ENTRIES)) begin
               rvalid_in = 1'b1;
               raddr_in  = addr_ff[AW-1:0];
               addr_in   = addr_ff + 1'b1;
            end
            if (rvalid_ff) begin
               if (rd_data.cached && rd_data.device == cmd_ff.device
                   && rd_data.inode == cmd_ff.inode_number) begin
                  if (!hit_ff) begin
                     hit_in = 1'b1; hit_idx_in = raddr_ff;
                  end
               end
               if (!rd_data.cached && !free_ff) begin
                  free_in = 1'b1; free_idx_in = raddr_ff;
               end
               if (rd_data.cached && rd_data.share == 8'd0
                   && (!vic_ff || rd_data.uses < vic_use_ff)) begin
                  vic_in = 1'b1; vic_idx_in = raddr_ff; vic_use_in = rd_data.uses;
               end
            end
            if (!rvalid_ff && addr_ff == (AW+1)'(ENTRIES)) begin
               // sweep done; re-read the target entry (hit, else free, else victim) for the update
               addr_in  = {1'b0, hit_ff ? hit_idx_ff : free_ff ? free_idx_ff : vic_idx_ff};
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            out_in = '0;
            out_valid_in = 1'b1;
            state_in = S_OUT;
            if (cmd_ff.op == OP_GET) begin
               out_in.entry_out = 6'(addr_ff[AW-1:0]);
               if (hit_ff) begin
                  out_in.status = ST_HIT;
                  wr_en = 1'b1;
                  wr_data = rd_data;
                  if (rd_data.share != 8'hFF) wr_data.share = rd_data.share + 8'd1;
                  if (rd_data.uses != 16'hFFFF) wr_data.uses = rd_data.uses + 16'd1;
               end else if (free_ff || vic_ff) begin
                  out_in.status = free_ff ? ST_LOAD_FREE : ST_REPLACE;
                  out_in.load_request = 1'b1;
                  out_in.device_out   = cmd_ff.device;
                  out_in.disk_block   = base_ff + ((cmd_ff.inode_number - 32'd1) >> SH);
                  out_in.block_offset = 3'((cmd_ff.inode_number - 32'd1)
                                           & 32'(INODES_PER_BLOCK - 1));
                  wr_en = 1'b1;
                  wr_data.cached = 1'b1;
                  wr_data.device = cmd_ff.device;
                  wr_data.inode  = cmd_ff.inode_number;
                  wr_data.share  = 8'd1;
                  wr_data.uses   = 16'd1;
               end else begin
                  out_in.status    = ST_FULL;
                  out_in.entry_out = '0;
               end
            end else begin
               out_in.entry_out = cmd_ff.entry_index;
               if (!rel_ok) begin
                  out_in.status = ST_IGNORED;
               end else begin
                  wr_en = 1'b1;
                  wr_data = rd_data;
                  wr_data.share = share_dec;
                  if (cmd_ff.dirty_in) wr_data.dirty = 1'b1;
                  if (share_dec == 8'd0 && (cmd_ff.dirty_in || rd_data.dirty)) begin
                     wr_data.dirty = 1'b0;
                     out_in.status = ST_RELEASED_WB;
                     out_in.writeback_request = 1'b1;
                     out_in.device_out   = rd_data.device;
                     out_in.disk_block   = base_ff + ((rd_data.inode - 32'd1) >> SH);
                     out_in.block_offset = 3'((rd_data.inode - 32'd1)
                                              & 32'(INODES_PER_BLOCK - 1));
                  end else begin
                     out_in.status = ST_RELEASED;
                  end
               end
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         base_ff      <= '0;
         hit_ff <= 1'b0; free_ff <= 1'b0; vic_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
         hit_ff <= hit_in; free_ff <= free_in; vic_ff <= vic_in;
         if (csr_write_enable) base_ff <= csr_write_data;
      end
      cmd_ff      <= cmd_in;
      raddr_ff    <= raddr_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      vic_idx_ff  <= vic_idx_in;
      vic_use_ff  <= vic_use_in;
      out_ff      <= out_in;
   end
endmodule

@@ rtl/core/ric_ram.sv @@
module ric_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
